@@ hw/rtl/ari_pkg.sv @@
// Shared constants, state types and control structs for the adjusted Rand index block.
package ari_pkg;

  localparam int unsigned MAX_CLUSTERS_DEF = 16;
  localparam int unsigned MAX_POINTS_DEF   = 65536;

  localparam int LABEL_W  = 8;
  localparam int CFG_K_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int NOUT_W   = 17;
  localparam int APB_A_W  = 3;
  localparam int APB_D_W  = 32;
  localparam int NUM_SHIFT = 31;

  localparam logic [CFG_K_W-1:0] K_RESET = 5'd16;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_CLUSTERS = 1'b0;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_RUN,
    ST_FLUSH,
    ST_WALK_ROW,
    ST_WALK_COL,
    ST_DRAIN,
    ST_CLEAR,
    ST_CALC
  } ari_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_PREP,
    CS_DIV,
    CS_FIN,
    CS_DONE
  } calc_state_t;

  typedef enum logic [1:0] {
    MUL_XM,
    MUL_YZ,
    MUL_MSUM
  } mul_step_t;

  typedef struct packed {
    logic start;
    logic ack;
  } calc_ctl_t;

  typedef struct packed {
    logic               done;
    logic               undef;
    logic [VALUE_W-1:0] value;
  } calc_res_t;

endpackage

@@ hw/rtl/ari_calc.sv @@
// Final ARI arithmetic: serial shift-add products and a restoring bit-serial divider.
module ari_calc import ari_pkg::*; #(
  parameter int SW = 34
) (
  input  logic          clk,
  input  logic          rst_n,
  input  calc_ctl_t     ctl,
  input  logic [SW-1:0] x_sum,
  input  logic [SW-1:0] y_sum,
  input  logic [SW-1:0] z_sum,
  input  logic [SW-1:0] m_pairs,
  output calc_res_t     res
);

  localparam int PW   = 2 * SW;
  localparam int NW   = PW + NUM_SHIFT;
  localparam int MC_W = $clog2(SW + 1);
  localparam int DC_W = $clog2(NW);

  calc_state_t cs_r, cs_nxt;
  mul_step_t   step_r;

  logic [PW-1:0]   a_sh_r;
  logic [SW:0]     b_r;
  logic [PW-1:0]   acc_r;
  logic [MC_W-1:0] mcnt_r;
  logic [PW-1:0]   xm_r, yz_r, myz_r;
  logic            neg_r;
  logic [NW-1:0]   num_r;
  logic [PW-1:0]   den_r;
  logic [PW-1:0]   rem_r;
  logic [32:0]     q_r;
  logic            ovf_r;
  logic [DC_W-1:0] dcnt_r;
  logic            undef_r;
  logic [VALUE_W-1:0] value_r;

  logic [PW-1:0] acc_sum;
  logic          mul_last;
  logic [PW-1:0] diff;
  logic          neg_c;
  logic [PW-1:0] den_c;
  logic [PW:0]   rem_sh;
  logic          ge;
  logic          div_last;
  logic [32:0]   q_sat;
  logic [SW:0]   yz_add;

  assign yz_add   = {1'b0, y_sum} + {1'b0, z_sum};
  assign acc_sum  = b_r[0] ? acc_r + a_sh_r : acc_r;
  assign mul_last = (mcnt_r == MC_W'(SW));
  assign neg_c    = (xm_r < yz_r);
  assign diff     = neg_c ? yz_r - xm_r : xm_r - yz_r;
  assign den_c    = myz_r - {yz_r[PW-2:0], 1'b0};
  assign rem_sh   = {rem_r, num_r[NW-1]};
  assign ge       = (rem_sh >= {1'b0, den_r});
  assign div_last = (dcnt_r == DC_W'(NW - 1));
  assign q_sat    = (ovf_r || (q_r > 33'h0_8000_0000)) ? 33'h0_8000_0000 : q_r;

  always_comb begin
    cs_nxt = cs_r;
    unique case (cs_r)
      CS_IDLE: if (ctl.start) cs_nxt = CS_MUL;
      CS_MUL:  if (mul_last && step_r == MUL_MSUM) cs_nxt = CS_PREP;
      CS_PREP: cs_nxt = (den_c == '0) ? CS_DONE : CS_DIV;
      CS_DIV:  if (div_last) cs_nxt = CS_FIN;
      CS_FIN:  cs_nxt = CS_DONE;
      CS_DONE: if (ctl.ack) cs_nxt = CS_IDLE;
      default: cs_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r <= CS_IDLE;
    end else begin
      cs_r <= cs_nxt;
      unique case (cs_r)
        CS_IDLE: begin
          step_r <= MUL_XM;
          a_sh_r <= PW'(x_sum);
          b_r    <= {1'b0, m_pairs};
          acc_r  <= '0;
          mcnt_r <= '0;
        end
        CS_MUL: begin
          if (mul_last) begin
            acc_r  <= '0;
            mcnt_r <= '0;
            unique case (step_r)
              MUL_XM: begin
                xm_r   <= acc_sum;
                step_r <= MUL_YZ;
                a_sh_r <= PW'(y_sum);
                b_r    <= {1'b0, z_sum};
              end
              MUL_YZ: begin
                yz_r   <= acc_sum;
                step_r <= MUL_MSUM;
                a_sh_r <= PW'(m_pairs);
                b_r    <= yz_add;
              end
              default: myz_r <= acc_sum;
            endcase
          end else begin
            acc_r  <= acc_sum;
            a_sh_r <= {a_sh_r[PW-2:0], 1'b0};
            b_r    <= {1'b0, b_r[SW:1]};
            mcnt_r <= mcnt_r + MC_W'(1);
          end
        end
        CS_PREP: begin
          neg_r   <= neg_c;
          num_r   <= NW'(diff) << NUM_SHIFT;
          den_r   <= den_c;
          rem_r   <= '0;
          q_r     <= '0;
          ovf_r   <= 1'b0;
          dcnt_r  <= '0;
          undef_r <= (den_c == '0);
          value_r <= '0;
        end
        CS_DIV: begin
          num_r  <= {num_r[NW-2:0], 1'b0};
          rem_r  <= PW'(ge ? rem_sh - {1'b0, den_r} : rem_sh);
          ovf_r  <= ovf_r | q_r[32];
          q_r    <= {q_r[31:0], ge};
          dcnt_r <= dcnt_r + DC_W'(1);
        end
        CS_FIN: begin
          if (neg_r) value_r <= VALUE_W'(33'd0 - q_sat);
          else if (q_sat > 33'h0_7FFF_FFFF) value_r <= 32'h7FFF_FFFF;
          else value_r <= q_sat[31:0];
        end
        default: ;
      endcase
    end
  end

  assign res.done  = (cs_r == CS_DONE);
  assign res.undef = undef_r;
  assign res.value = value_r;

endmodule

@@ hw/rtl/adjusted_rand_index_top.sv @@
// Top level: label intake, contingency table memory, final walk and result register.
// Throughput: one transaction per cycle while collecting a set (one table read-modify-write).
// After the last transaction: flush, row walk then column walk over the K*K table, drain,
//   table clear, then the serial multiply/divide unit computes the result.
// Input stalls from the last transaction until the result is loaded into the output register.
// Reset (rst_n low, synchronous): K returns to 16, then a clearing pass over all CELLS
//   table entries zeroes the table while in_stall is held high.
module adjusted_rand_index_top import ari_pkg::*; #(
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input transactions
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [LABEL_W-1:0]  in_est_label,
  input  logic [LABEL_W-1:0]  in_ref_label,
  input  logic                in_last_item,
  // result transactions
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VALUE_W-1:0]  out_ari_value,
  output logic                out_undefined_flag,
  output logic [NOUT_W-1:0]   out_point_count,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_A_W-1:0]  paddr,
  input  logic [APB_D_W-1:0]  pwdata,
  output logic [APB_D_W-1:0]  prdata,
  output logic                pready
);

  localparam int CELLS  = MAX_CLUSTERS * MAX_CLUSTERS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(MAX_CLUSTERS);
  localparam int K_W    = $clog2(MAX_CLUSTERS + 1);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SW     = 2 * CNT_W;

  ari_state_t state_r, state_nxt;

  logic [CFG_K_W-1:0] num_clusters_r;

  // contingency table: one write port, one registered read port
  logic [CNT_W-1:0]  mem [CELLS];
  logic [CNT_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              mem_we;

  // intake pipeline and write-back forwarding
  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              wr_en_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [CNT_W-1:0]  wr_val_r;
  logic [CNT_W-1:0]  s1_cur, s1_sum;

  logic [CNT_W-1:0]  points_r;
  logic [CNT_W-1:0]  n_hold_r;
  logic [SW-1:0]     m_r;

  // walk counters and pipeline tags
  logic [IDX_W-1:0]  wi_r, wj_r;
  logic              t0_valid_r, t0_end_r, t0_col_r;
  logic              t1_valid_r, t1_end_r, t1_col_r;
  logic              t2_valid_r, t2_col_r;
  logic [CNT_W-1:0]  tot_acc_r, totq_r;
  logic [SW-1:0]     pc_r, pt_r;
  logic [SW-1:0]     x_r, y_r, z_r;

  logic [ADDR_W-1:0] clr_r;

  logic              out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic              out_flag_r;
  logic [NOUT_W-1:0] out_n_r;

  calc_ctl_t calc_ctl;
  calc_res_t calc_res;

  logic              in_acc, room, est_ok, ref_ok, cfg_wr;
  logic [K_W-1:0]    k_eff;
  logic [IDX_W-1:0]  k_m1;
  logic [ADDR_W-1:0] in_addr, walk_addr;
  logic              row_end, walk_last, clr_last, pipe_empty, out_free;
  logic [CNT_W-1:0]  tot_sum;
  logic [SW-1:0]     cell_prod, tot_prod, n_prod;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_CLUSTERS);
  assign prdata = (paddr[2] == REG_NUM_CLUSTERS) ? APB_D_W'(num_clusters_r) : '0;

  // K above the table size acts as the table size
  always_comb begin
    if (32'(num_clusters_r) > MAX_CLUSTERS) k_eff = K_W'(MAX_CLUSTERS);
    else k_eff = K_W'(num_clusters_r);
  end
  assign k_m1 = IDX_W'(k_eff - K_W'(1));

  // ---------------- intake ----------------
  assign in_acc = in_valid && !in_stall;
  assign room   = (32'(points_r) < MAX_POINTS);
  assign est_ok = (in_est_label != '0) && (32'(in_est_label) <= 32'(k_eff));
  assign ref_ok = (in_ref_label != '0) && (32'(in_ref_label) <= 32'(k_eff));
  assign in_addr = ADDR_W'((32'(in_est_label) - 32'd1) * MAX_CLUSTERS
                           + (32'(in_ref_label) - 32'd1));

  // last cycle's write is not yet visible in the read data
  assign s1_cur = (wr_en_r && wr_addr_r == s1_addr_r) ? wr_val_r : rd_data_r;
  assign s1_sum = s1_cur + CNT_W'(1);

  // ---------------- walk ----------------
  assign walk_addr = (state_r == ST_WALK_COL)
                   ? ADDR_W'(32'(wj_r) * MAX_CLUSTERS + 32'(wi_r))
                   : ADDR_W'(32'(wi_r) * MAX_CLUSTERS + 32'(wj_r));
  assign row_end    = (wj_r == k_m1);
  assign walk_last  = row_end && (wi_r == k_m1);
  assign clr_last   = (clr_r == ADDR_W'(CELLS - 1));
  assign pipe_empty = !t0_valid_r && !t1_valid_r && !t2_valid_r;
  assign out_free   = !out_valid_r || !out_stall;

  assign tot_sum   = tot_acc_r + rd_data_r;
  assign cell_prod = SW'(rd_data_r) * SW'(rd_data_r - CNT_W'(1));
  assign tot_prod  = SW'(totq_r) * SW'(totq_r - CNT_W'(1));
  assign n_prod    = SW'(n_hold_r) * SW'(n_hold_r - CNT_W'(1));

  // ---------------- memory ports ----------------
  assign mem_raddr = (state_r == ST_RUN) ? in_addr : walk_addr;

  always_comb begin
    if (state_r == ST_INIT || state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_valid_r;
      mem_waddr = s1_addr_r;
      mem_wdata = s1_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    calc_ctl.start = 1'b0;
    calc_ctl.ack   = 1'b0;
    unique case (state_r)
      ST_INIT:     if (clr_last) state_nxt = ST_RUN;
      ST_RUN: begin
        in_stall = 1'b0;
        if (in_valid && in_last_item) state_nxt = ST_FLUSH;
      end
      ST_FLUSH:    state_nxt = (k_eff == '0) ? ST_DRAIN : ST_WALK_ROW;
      ST_WALK_ROW: if (walk_last) state_nxt = ST_WALK_COL;
      ST_WALK_COL: if (walk_last) state_nxt = ST_DRAIN;
      ST_DRAIN:    if (pipe_empty) state_nxt = ST_CLEAR;
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt      = ST_CALC;
          calc_ctl.start = 1'b1;
        end
      end
      ST_CALC: begin
        if (calc_res.done && out_free) begin
          calc_ctl.ack = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_INIT;
      num_clusters_r <= K_RESET;
      clr_r          <= '0;
      points_r       <= '0;
      s1_valid_r     <= 1'b0;
      wr_en_r        <= 1'b0;
      t0_valid_r     <= 1'b0;
      t1_valid_r     <= 1'b0;
      t2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) num_clusters_r <= pwdata[CFG_K_W-1:0];

      // intake: read on accept, add and write back in the following cycle
      s1_valid_r <= in_acc && room && est_ok && ref_ok;
      s1_addr_r  <= in_addr;
      wr_en_r    <= s1_valid_r;
      wr_addr_r  <= s1_addr_r;
      wr_val_r   <= s1_sum;
      if (in_acc && room) points_r <= points_r + CNT_W'(1);

      m_r <= n_prod >> 1;

      if (state_r == ST_FLUSH) begin
        n_hold_r  <= points_r;
        points_r  <= '0;
        x_r       <= '0;
        y_r       <= '0;
        z_r       <= '0;
        tot_acc_r <= '0;
        wi_r      <= '0;
        wj_r      <= '0;
      end

      // walk issue: rows first, then columns
      if (state_r == ST_WALK_ROW || state_r == ST_WALK_COL) begin
        t0_valid_r <= 1'b1;
        t0_end_r   <= row_end;
        t0_col_r   <= (state_r == ST_WALK_COL);
        if (row_end) begin
          wj_r <= '0;
          wi_r <= (wi_r == k_m1) ? '0 : wi_r + IDX_W'(1);
        end else begin
          wj_r <= wj_r + IDX_W'(1);
        end
      end else begin
        t0_valid_r <= 1'b0;
      end

      // cell pairs and line totals
      t1_valid_r <= t0_valid_r;
      t1_end_r   <= t0_end_r;
      t1_col_r   <= t0_col_r;
      pc_r       <= cell_prod >> 1;
      if (t0_valid_r) begin
        if (t0_end_r) begin
          totq_r    <= tot_sum;
          tot_acc_r <= '0;
        end else begin
          tot_acc_r <= tot_sum;
        end
      end

      t2_valid_r <= t1_valid_r && t1_end_r;
      t2_col_r   <= t1_col_r;
      pt_r       <= tot_prod >> 1;
      if (t1_valid_r && !t1_col_r) x_r <= x_r + pc_r;

      if (t2_valid_r) begin
        if (t2_col_r) z_r <= z_r + pt_r;
        else y_r <= y_r + pt_r;
      end

      if (state_r == ST_INIT || state_r == ST_CLEAR) begin
        clr_r <= clr_last ? '0 : clr_r + ADDR_W'(1);
      end

      // output register
      if (calc_ctl.ack) begin
        out_valid_r <= 1'b1;
        out_value_r <= calc_res.undef ? '0 : calc_res.value;
        out_flag_r  <= calc_res.undef;
        out_n_r     <= NOUT_W'(n_hold_r);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  ari_calc #(
    .SW(SW)
  ) u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (calc_ctl),
    .x_sum   (x_r),
    .y_sum   (y_r),
    .z_sum   (z_r),
    .m_pairs (m_r),
    .res     (calc_res)
  );

  assign out_valid          = out_valid_r;
  assign out_ari_value      = out_value_r;
  assign out_undefined_flag = out_flag_r;
  assign out_point_count    = out_n_r;

`ifndef SYNTHESIS
  a_s1_in_intake: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (state_r == ST_RUN || state_r == ST_FLUSH))
    else $error("table update outside intake");

  a_walk_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> pipe_empty)
    else $error("clear started with walk in flight");

  a_points_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(points_r) <= MAX_POINTS)
    else $error("point count past limit");

  a_calc_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    calc_res.done |-> (state_r == ST_CALC))
    else $error("calc result outside calc phase");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    calc_ctl.ack |=> out_valid_r)
    else $error("result not loaded");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the adjusted Rand index block.
`timescale 1ns / 100ps

// Expected-result store and contingency predictor for the adjusted Rand index.
class ari_scoreboard;
  typedef struct {
    logic [31:0] ari;
    logic        undef;
    logic [16:0] npts;
  } ari_result_t;

  int unsigned   table_cnt[16][16];
  int unsigned   points;
  int unsigned   k_reg;
  ari_result_t   pending[$];
  int unsigned   errors;
  int unsigned   sets_checked;
  int unsigned   undef_seen;
  int unsigned   neg_seen;

  function new();
    foreach (table_cnt[r, c]) table_cnt[r][c] = 0;
    points = 0;
    k_reg = 16;
    errors = 0;
    sets_checked = 0;
    undef_seen = 0;
    neg_seen = 0;
  endfunction

  function void set_k(int unsigned val);
    k_reg = val & 5'h1f;
  endfunction

  function logic [127:0] pair_count(logic [127:0] c);
    return (c == 0) ? 128'd0 : c * (c - 1) / 2;
  endfunction

  // Count one accepted labelled point; on the last point, work out the ARI.
  function void note_point(logic [7:0] est, logic [7:0] rl, logic last);
    int unsigned  k;
    logic [127:0] x, y, z, m, xm, yz, num, den, q, row_t, col_t;
    logic         neg;
    ari_result_t  res;
    k = (k_reg > 16) ? 16 : k_reg;
    if (points < 65536) begin
      points++;
      if (est >= 1 && est <= k && rl >= 1 && rl <= k) table_cnt[est-1][rl-1]++;
    end
    if (!last) return;
    x = 0; y = 0; z = 0;
    for (int r = 0; r < k; r++) begin
      row_t = 0; col_t = 0;
      for (int c = 0; c < k; c++) begin
        row_t += table_cnt[r][c];
        col_t += table_cnt[c][r];
        x += pair_count(table_cnt[r][c]);
      end
      y += pair_count(row_t);
      z += pair_count(col_t);
    end
    m = pair_count(points);
    xm = x * m;
    yz = y * z;
    neg = xm < yz;
    num = (neg ? yz - xm : xm - yz) << 31;
    den = m * (y + z) - (yz << 1);
    res.undef = 1'b0;
    res.ari = '0;
    if (den == 0) begin
      res.undef = 1'b1;
    end else begin
      q = num / den;
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      if (neg) res.ari = 32'd0 - q[31:0];
      else res.ari = (q > 128'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    end
    res.npts = points[16:0];
    pending.push_back(res);
    foreach (table_cnt[r, c]) table_cnt[r][c] = 0;
    points = 0;
  endfunction

  function void check_result(logic [31:0] ari, logic undef, logic [16:0] npts);
    ari_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result: ari=%h undef=%b n=%0d", ari, undef, npts);
      errors++;
      return;
    end
    e = pending.pop_front();
    sets_checked++;
    if (undef) undef_seen++;
    if (ari[31]) neg_seen++;
    if (ari !== e.ari) begin
      $error("ari_value: expected %h, got %h", e.ari, ari);
      errors++;
    end
    if (undef !== e.undef) begin
      $error("undefined_flag: expected %b, got %b", e.undef, undef);
      errors++;
    end
    if (npts !== e.npts) begin
      $error("point_count: expected %0d, got %0d", e.npts, npts);
      errors++;
    end
  endfunction
endclass

module testbench;
  import ari_pkg::*;

  localparam int DRAIN_CYCLES = 1500;  // flush + walk + clear + serial calc, with margin

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [LABEL_W-1:0]  in_est_label = '0;
  logic [LABEL_W-1:0]  in_ref_label = '0;
  logic                in_last_item = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VALUE_W-1:0]  out_ari_value;
  logic                out_undefined_flag;
  logic [NOUT_W-1:0]   out_point_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_A_W-1:0]  paddr = '0;
  logic [APB_D_W-1:0]  pwdata = '0;
  logic [APB_D_W-1:0]  prdata;
  logic                pready;

  // percent of cycles the sender idles / the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // long receiver hold-off, requested by the stimulus, counted in the receiver
  logic        hold_request = 1'b0;
  int unsigned points_sent = 0;

  ari_scoreboard board = new();

  adjusted_rand_index_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_est_label(in_est_label), .in_ref_label(in_ref_label),
    .in_last_item(in_last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ari_value(out_ari_value), .out_undefined_flag(out_undefined_flag),
    .out_point_count(out_point_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Result side: random stall, plus one long hold-off when asked. A result
  // transaction is taken at an edge where out_valid is high and out_stall low;
  // both are read before this edge's updates land.
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        board.check_result(out_ari_value, out_undefined_flag, out_point_count);
      if (hold_request && hold_left == 0) hold_left = 3000;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one labelled point and wait for the block to take it.
  task automatic send_point(logic [7:0] est, logic [7:0] rl, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_est_label <= est;
    in_ref_label <= rl;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_point(est, rl, last);
    points_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected result has come out, then let the block settle.
  task automatic wait_idle();
    stop_sending();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of num_clusters: setup cycle, then access cycle (pready always high).
  task automatic write_num_clusters(int unsigned val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {REG_NUM_CLUSTERS, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_k(val);
    @(posedge clk);
  endtask

  // One data set: mostly labels in 1..K following a noisy mapping so the
  // ARI lands all over its range; a few stray labels anywhere in 0..255.
  task automatic send_random_set(int unsigned k, int unsigned len);
    int unsigned   kk, noise_pct, agree_pct, shift;
    logic [7:0]    est, rl;
    kk = (k == 0) ? 1 : ((k > 16) ? 16 : k);
    noise_pct = $urandom_range(10);
    agree_pct = $urandom_range(100);
    shift = $urandom_range(kk - 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        est = 8'($urandom_range(255));
        rl  = 8'($urandom_range(255));
      end else begin
        est = 8'($urandom_range(kk, 1));
        if ($urandom_range(99) < agree_pct) rl = 8'(((est - 1 + shift) % kk) + 1);
        else rl = 8'($urandom_range(kk, 1));
      end
      send_point(est, rl, i == len - 1);
    end
  endtask

  task automatic random_phase(int unsigned k, int unsigned idle_pct, int unsigned stall_pct,
                              int unsigned n_points);
    int unsigned goal;
    wait_idle();
    write_num_clusters(k);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    goal = points_sent + n_points;
    while (points_sent < goal) begin
      // mostly small sets, now and then a bigger one
      if ($urandom_range(9) == 0) send_random_set(k, $urandom_range(120, 40));
      else send_random_set(k, $urandom_range(20, 1));
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed sets at the reset value K = 16 ----
    send_point(8'd1, 8'd1, 1'b1);                 // single point: zero denominator
    send_point(8'd1, 8'd1, 1'b0);                 // perfect agreement: ARI = 1.0
    send_point(8'd1, 8'd1, 1'b0);
    send_point(8'd16, 8'd16, 1'b0);
    send_point(8'd16, 8'd16, 1'b1);
    send_point(8'd1, 8'd1, 1'b0);                 // crossed labels: negative ARI
    send_point(8'd1, 8'd2, 1'b0);
    send_point(8'd2, 8'd1, 1'b0);
    send_point(8'd2, 8'd2, 1'b1);
    send_point(8'd0, 8'd255, 1'b0);               // labels out of range still count in n
    send_point(8'd255, 8'd0, 1'b0);
    send_point(8'd17, 8'd3, 1'b0);
    send_point(8'd170, 8'd85, 1'b1);
    // K changed in mid set: cells beyond the new corner are ignored
    send_point(8'd5, 8'd5, 1'b0);
    send_point(8'd5, 8'd5, 1'b0);
    send_point(8'd1, 8'd2, 1'b0);
    wait_idle();
    write_num_clusters(2);
    send_point(8'd2, 8'd2, 1'b0);
    send_point(8'd1, 8'd2, 1'b1);
    // K of 1 and K of 0
    wait_idle();
    write_num_clusters(1);
    send_point(8'd1, 8'd1, 1'b0);
    send_point(8'd1, 8'd1, 1'b0);
    send_point(8'd2, 8'd1, 1'b1);
    wait_idle();
    write_num_clusters(0);
    send_point(8'd1, 8'd1, 1'b0);
    send_point(8'd1, 8'd1, 1'b1);

    // ---- random sets, across idling phases and register settings ----
    random_phase(16, 0, 0, 450);
    random_phase(2, 83, 0, 300);
    random_phase(31, 0, 83, 300);
    random_phase(7, 16, 16, 450);
    random_phase(3, 0, 0, 220);

    // receiver holds off while the sender keeps offering sets
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    for (int s = 0; s < 6; s++) send_random_set(3, $urandom_range(10, 2));

    wait_idle();
    $display("Covered %0d points in %0d data sets (%0d undefined, %0d negative ARI),",
             points_sent, board.sets_checked, board.undef_seen, board.neg_seen);
    $display("K settings 0, 1, 2, 3, 7, 16, 31, stray labels and a long output hold-off.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (board.pending.size() != 0)
        $error("%0d expected results never arrived", board.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #30ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
